/* sv/wbps_pkg.sv */
// Shared types and constants for the wildcard byte pattern scanner.
// Holds the request and result payloads, opcode and register codes, and the window cell controls.
// No dependencies.
package wbps_pkg;

	localparam int PatternMaxDefault = 64;
	localparam int IndexWidth        = 6;
	localparam int ByteWidth         = 8;
	localparam int AddrWidth         = 64;
	localparam int LenWidth          = 7;
	localparam int CountWidth        = 8;

	localparam logic [LenWidth-1:0]   LenReset   = 7'd1;
	localparam logic [CountWidth-1:0] LimitReset = 8'd50;

	typedef enum logic [1:0] {
		OpLoad  = 2'd0,
		OpStart = 2'd1,
		OpData  = 2'd2
	} opcode_t;

	typedef enum logic [0:0] {
		RegPatternLength = 1'b0,
		RegMaxMatches    = 1'b1
	} reg_index_t;

	typedef struct packed {
		opcode_t                opcode;
		logic [IndexWidth-1:0]  pattern_index;
		logic [ByteWidth-1:0]   pattern_value;
		logic                   pattern_care;
		logic [ByteWidth-1:0]   data_value;
		logic [AddrWidth-1:0]   data_address;
	} item_t;

	typedef struct packed {
		logic [AddrWidth-1:0]   match_address;
		logic [CountWidth-1:0]  match_number;
		logic                   limit_reached;
	} result_t;

	// Broadcast controls for the row of window cells.
	typedef struct packed {
		logic                   clear;
		logic                   shift;
		logic                   rotate;
		logic [ByteWidth-1:0]   new_byte;
		logic                   load;
		logic [IndexWidth-1:0]  load_index;
		logic [ByteWidth-1:0]   load_value;
		logic                   load_care;
	} win_ctrl_t;

endpackage

/* sv/wbps_cell.sv */
// One cell of the scan row: a window byte on a ring, a pattern byte and its care bit.
// Depends on wbps_pkg for the control struct.
module wbps_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wbps_pkg::win_ctrl_t                 ctrl,
	input  logic                                insert_here,
	input  logic                                load_here,
	input  logic                                active,
	input  logic [wbps_pkg::ByteWidth-1:0]      shift_in,
	input  logic [wbps_pkg::ByteWidth-1:0]      rotate_in,
	output logic [wbps_pkg::ByteWidth-1:0]      window,
	output logic                                hit
);

	logic [wbps_pkg::ByteWidth-1:0] win_q;
	logic [wbps_pkg::ByteWidth-1:0] pat_q;
	logic                           care_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctrl.clear) begin
			win_q <= '0;
		end else if (ctrl.shift) begin
			win_q <= insert_here ? ctrl.new_byte : shift_in;
		end else if (ctrl.rotate) begin
			win_q <= rotate_in;
		end
	end

	// Pattern entries are undefined until loaded.
	always_ff @(posedge clk) begin
		if (load_here) begin
			pat_q  <= ctrl.load_value;
			care_q <= ctrl.load_care;
		end
	end

	assign window = win_q;
	assign hit    = !active || !care_q || (win_q == pat_q);

endmodule

/* sv/wbps_chain.sv */
// Row of scan cells closed into a ring, with per-cell decode and the match reduction.
// Depends on wbps_pkg and wbps_cell.
module wbps_chain #(
	parameter int PATTERN_MAX = wbps_pkg::PatternMaxDefault,
	parameter int IW          = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1,
	parameter int LW          = $clog2(PATTERN_MAX + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wbps_pkg::win_ctrl_t ctrl,
	input  logic [IW-1:0]       insert_index,
	input  logic [LW-1:0]       active_len,
	output logic                all_hit
);

	logic [wbps_pkg::ByteWidth-1:0] bytes [PATTERN_MAX];
	logic [PATTERN_MAX-1:0]         hits;

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
		localparam int Next = (j + 1) % PATTERN_MAX;
		localparam int Prev = (j + PATTERN_MAX - 1) % PATTERN_MAX;

		logic insert_here;
		logic load_here;
		logic active;

		assign insert_here = (insert_index == IW'(j));
		assign load_here   = ctrl.load && (32'(ctrl.load_index) == 32'(j));
		assign active      = (32'(active_len) > 32'(j));

		wbps_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.insert_here (insert_here),
			.load_here   (load_here),
			.active      (active),
			.shift_in    (bytes[Next]),
			.rotate_in   (bytes[Prev]),
			.window      (bytes[j]),
			.hit         (hits[j])
		);
	end

	assign all_hit = &hits;

endmodule

/* sv/wildcard_byte_pattern_scanner.sv */
// Top level of the wildcard byte pattern scanner: handshakes, registers, counters, result stage.
// Depends on wbps_pkg and wbps_chain (which uses wbps_cell).
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+-------------------------------
//   item     | in        | item_valid / item_ready     | wbps_pkg::item_t
//   result   | out       | result_valid / result_ready | wbps_pkg::result_t
//   cfg      | in        | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// A data byte is compared against the pattern in the next cycle (stage s1) while the following
// request may already enter, so the block sustains one request per cycle when not stalled.
// The s1 compare across all cells and the single result register set this. A pattern_length
// write realigns the window ring one cell per cycle, with item_ready low until the insertion
// point reaches cell len-1. Reset clears the window, counters and control at once; pattern
// entries have no reset. A stalled result holds s1, which holds item_ready low.
module wildcard_byte_pattern_scanner #(
	parameter int PATTERN_MAX = wbps_pkg::PatternMaxDefault
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  wbps_pkg::item_t                    item,
	output logic                               result_valid,
	input  logic                               result_ready,
	output wbps_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  wbps_pkg::reg_index_t               cfg_index,
	input  logic [wbps_pkg::CountWidth-1:0]    cfg_data
);

	localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LW = $clog2(PATTERN_MAX + 1);

	// Configuration registers.
	logic [wbps_pkg::LenWidth-1:0]   len_q;
	logic [wbps_pkg::CountWidth-1:0] limit_q;

	// Scan state.
	logic [LW-1:0]                   fill_q;
	logic [wbps_pkg::CountWidth-1:0] count_q;
	logic [IW-1:0]                   ins_q;

	// Compare stage.
	logic                            s1_valid_s1;
	logic [wbps_pkg::AddrWidth-1:0]  addr_s1;

	// Result register.
	logic                            result_valid_q;
	wbps_pkg::result_t               result_q;

	logic [31:0]                     len_w;
	logic [31:0]                     eff_w;
	logic [LW-1:0]                   act_len;
	logic [IW-1:0]                   target_ins;
	logic                            rot_busy;
	logic [wbps_pkg::CountWidth-1:0] limit_eff;
	logic                            all_hit;
	logic                            report;
	logic                            s1_stall;
	logic                            accept;
	logic                            is_load;
	logic                            is_start;
	logic                            is_data;
	wbps_pkg::win_ctrl_t             ctrl;

	// Clamp the length into 1..PATTERN_MAX and the limit to at least one.
	assign len_w = 32'(len_q);
	always_comb begin
		if (len_w == 32'd0) begin
			eff_w = 32'd1;
		end else if (len_w > 32'(PATTERN_MAX)) begin
			eff_w = 32'(PATTERN_MAX);
		end else begin
			eff_w = len_w;
		end
	end
	assign act_len    = eff_w[LW-1:0];
	assign target_ins = IW'(eff_w - 32'd1);
	assign limit_eff  = (limit_q == '0) ? wbps_pkg::CountWidth'(1) : limit_q;

	// The ring inserts the newest byte at cell len-1; realign after a length change.
	assign rot_busy = (ins_q != target_ins);

	// A data byte reports when the window is full, every cared cell hits, and the
	// scan limit is not yet used up.
	assign report   = s1_valid_s1 && (fill_q >= act_len) && all_hit && (count_q < limit_eff);
	assign s1_stall = report && result_valid_q && !result_ready;

	assign item_ready = !rot_busy && !s1_stall;
	assign cfg_ready  = 1'b1;
	assign accept     = item_valid && item_ready;

	always_comb begin
		is_load  = 1'b0;
		is_start = 1'b0;
		is_data  = 1'b0;
		case (item.opcode)
			wbps_pkg::OpLoad:  is_load  = accept;
			wbps_pkg::OpStart: is_start = accept;
			wbps_pkg::OpData:  is_data  = accept;
			default: ;
		endcase
	end

	always_comb begin
		ctrl.clear      = is_start;
		ctrl.shift      = is_data;
		ctrl.rotate     = rot_busy;
		ctrl.new_byte   = item.data_value;
		ctrl.load       = is_load && (32'(item.pattern_index) < 32'(PATTERN_MAX));
		ctrl.load_index = item.pattern_index;
		ctrl.load_value = item.pattern_value;
		ctrl.load_care  = item.pattern_care;
	end

	wbps_chain #(
		.PATTERN_MAX (PATTERN_MAX),
		.IW          (IW),
		.LW          (LW)
	) u_chain (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.insert_index (ins_q),
		.active_len   (act_len),
		.all_hit      (all_hit)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= wbps_pkg::LenReset;
			limit_q <= wbps_pkg::LimitReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wbps_pkg::RegPatternLength: len_q   <= cfg_data[wbps_pkg::LenWidth-1:0];
				wbps_pkg::RegMaxMatches:    limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Step the insertion point one cell per ring rotation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_q <= '0;
		end else if (rot_busy) begin
			ins_q <= (ins_q == IW'(PATTERN_MAX - 1)) ? '0 : ins_q + IW'(1);
		end
	end

	// Window fill saturates at the ring size; start drops it to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (is_start) begin
			fill_q <= '0;
		end else if (is_data && (fill_q < LW'(PATTERN_MAX))) begin
			fill_q <= fill_q + LW'(1);
		end
	end

	// Start wins over a report from the previous byte in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (is_start) begin
			count_q <= '0;
		end else if (report && !s1_stall) begin
			count_q <= count_q + wbps_pkg::CountWidth'(1);
		end
	end

	// Compare stage: hold while the result register is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (is_data) begin
			s1_valid_s1 <= 1'b1;
		end else if (!s1_stall) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_data) begin
			addr_s1 <= item.data_address - wbps_pkg::AddrWidth'(eff_w - 32'd1);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (report && !s1_stall) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report && !s1_stall) begin
			result_q.match_address <= addr_s1;
			result_q.match_number  <= count_q + wbps_pkg::CountWidth'(1);
			result_q.limit_reached <= ((count_q + wbps_pkg::CountWidth'(1)) == limit_eff);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A report never overwrites a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(report && !s1_stall) |-> (!result_valid_q || result_ready))
		else $error("result register overwritten");

	// A reported match carries the next ordinal of the scan.
	a_ordinal: assert property (@(posedge clk) disable iff (!arst_n)
		(report && !s1_stall) |=> (result_valid_q &&
			result_q.match_number == $past(count_q) + wbps_pkg::CountWidth'(1)))
		else $error("match ordinal mismatch");

	// Window fill stays within the ring.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LW'(PATTERN_MAX))
		else $error("window fill beyond ring size");

	// No data or start request enters while the ring is realigning.
	a_no_accept_rot: assert property (@(posedge clk) disable iff (!arst_n)
		rot_busy |-> !(ctrl.shift || ctrl.clear))
		else $error("window change during realignment");

endmodule

/* test/wildcard_byte_pattern_scanner_tb.sv */
// Self-checking testbench for the wildcard byte pattern scanner: random and directed scans
// checked against a behavioral scan predictor. Depends on wbps_pkg and the scanner RTL.
module wildcard_byte_pattern_scanner_tb;
	import wbps_pkg::*;

	localparam int PatMax        = PatternMaxDefault;
	// Quiet cycles before a register write; covers the two-stage pipe with margin.
	localparam int SettleCycles  = 8;
	// Cycles with no handshake at all before the run is declared hung. The slowest legal
	// stretch is a long result stall plus a full ring realign plus the settle pause.
	localparam int WatchdogLimit = 2000;
	localparam int TargetItems   = 1350;

	// Opcode 3 has no meaning; the block must swallow it without a result.
	localparam opcode_t OpUnused = opcode_t'(2'd3);

	typedef struct {
		logic                  is_write;
		item_t                 req;
		reg_index_t            reg_sel;
		logic [CountWidth-1:0] reg_value;
	} step_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	reg_index_t            cfg_index    = RegPatternLength;
	logic [CountWidth-1:0] cfg_data     = '0;

	wildcard_byte_pattern_scanner dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Scan predictor: its own copy of the pattern, window and registers.
	// ------------------------------------------------------------------
	logic [ByteWidth-1:0]  pred_pat  [PatMax];
	logic                  pred_care [PatMax];
	logic [ByteWidth-1:0]  pred_win  [PatMax] = '{default: '0};
	int unsigned           pred_fill  = 0;
	int unsigned           pred_found = 0;
	logic [LenWidth-1:0]   reg_length = LenReset;
	logic [CountWidth-1:0] reg_limit  = LimitReset;

	result_t               match_q [$];
	int unsigned           matches_predicted = 0;
	int unsigned           matches_seen      = 0;
	int unsigned           mismatch_count    = 0;

	// Advance the predictor by one accepted request; queue the match it reports, if any.
	task automatic scan_step(input item_t r);
		int unsigned len;
		int unsigned lim;
		bit          hit;
		result_t     m;
		case (r.opcode)
			OpLoad: begin
				pred_pat[r.pattern_index]  = r.pattern_value;
				pred_care[r.pattern_index] = r.pattern_care;
			end
			OpStart: begin
				for (int k = 0; k < PatMax; k++)
					pred_win[k] = '0;
				pred_fill  = 0;
				pred_found = 0;
			end
			OpData: begin
				// Out-of-range lengths clamp to 1..PatMax, a zero limit acts as 1.
				len = (reg_length == 0) ? 1 : (reg_length > PatMax) ? PatMax : reg_length;
				lim = (reg_limit == 0) ? 1 : reg_limit;
				for (int k = PatMax - 1; k > 0; k--)
					pred_win[k] = pred_win[k-1];
				pred_win[0] = r.data_value;
				if (pred_fill < PatMax)
					pred_fill++;
				// Position j of the pattern lines up with the byte received len-1-j items ago.
				hit = (pred_fill >= len);
				for (int j = 0; j < len; j++)
					if (pred_care[j] && pred_win[len-1-j] != pred_pat[j])
						hit = 1'b0;
				// Past the limit a match is dropped and the count is held.
				if (hit && pred_found < lim) begin
					pred_found++;
					m.match_address = r.data_address - 64'(len - 1);
					m.match_number  = pred_found[CountWidth-1:0];
					m.limit_reached = (pred_found == lim);
					match_q.push_back(m);
					matches_predicted++;
				end
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Idle patterns: mostly short gaps, a few long ones, and calm stretches.
	// ------------------------------------------------------------------
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	function automatic int unsigned gap_length(inout bit calm);
		int unsigned r;
		if ($urandom_range(0, 79) == 0)
			calm = !calm;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Driver: feeds requests and register writes from the pending queue.
	// ------------------------------------------------------------------
	step_t       pending_q [$];
	int unsigned send_gap        = 0;
	int unsigned quiet_cycles    = 0;
	int unsigned requests_taken  = 0;
	int unsigned writes_taken    = 0;

	always @(posedge clk or negedge arst_n) begin : drive
		logic  valid_next;
		logic  write_next;
		step_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			cfg_valid  <= 1'b0;
		end else begin
			valid_next = item_valid;
			write_next = cfg_valid;
			if (item_valid && item_ready) begin
				scan_step(item);
				requests_taken++;
				valid_next = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == RegPatternLength)
					reg_length = cfg_data[LenWidth-1:0];
				else
					reg_limit = cfg_data;
				writes_taken++;
				write_next = 1'b0;
			end
			// Count cycles with every predicted match delivered and no request entering.
			// matches_seen moves by NBA, so this read never races the monitor.
			if (matches_predicted == matches_seen && !(item_valid && item_ready))
				quiet_cycles++;
			else
				quiet_cycles = 0;
			// Launch the next step only from an empty channel; a back-to-back request keeps
			// item_valid high through this single assignment.
			if (!valid_next && !write_next) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_q.size() > 0) begin
					nxt = pending_q[0];
					if (!nxt.is_write) begin
						item       <= nxt.req;
						valid_next = 1'b1;
						void'(pending_q.pop_front());
						send_gap   = gap_length(send_calm);
					end else if (quiet_cycles >= SettleCycles) begin
						// Registers move only with the block drained and settled.
						cfg_index  <= nxt.reg_sel;
						cfg_data   <= nxt.reg_value;
						write_next = 1'b1;
						void'(pending_q.pop_front());
					end
				end
			end
			item_valid <= valid_next;
			cfg_valid  <= write_next;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: stalls the result side and checks every match in order.
	// ------------------------------------------------------------------
	int unsigned recv_stall = 0;

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
			matches_seen <= 0;
		end else begin
			if (result_valid && result_ready) begin
				matches_seen <= matches_seen + 1;
				if (match_q.size() == 0) begin
					$error("unexpected match: address %h number %0d limit %0b",
						result.match_address, result.match_number, result.limit_reached);
					mismatch_count++;
				end else begin
					want = match_q.pop_front();
					if (result.match_address !== want.match_address) begin
						$error("match_address: expected %h, got %h",
							want.match_address, result.match_address);
						mismatch_count++;
					end
					if (result.match_number !== want.match_number) begin
						$error("match_number: expected %0d, got %0d",
							want.match_number, result.match_number);
						mismatch_count++;
					end
					if (result.limit_reached !== want.limit_reached) begin
						$error("limit_reached: expected %0b, got %0b",
							want.limit_reached, result.limit_reached);
						mismatch_count++;
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				recv_stall   = gap_length(recv_calm);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: a long run of cycles with no handshake means a hang.
	// ------------------------------------------------------------------
	int unsigned stuck_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (cfg_valid && cfg_ready) ||
					(result_valid && result_ready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= WatchdogLimit) begin
				$display("wildcard_byte_pattern_scanner test failed");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus builder. gen_* mirror what the queued requests will load, so
	// pattern instances can be planted in the stream.
	// ------------------------------------------------------------------
	logic [ByteWidth-1:0] gen_pat  [PatMax];
	logic                 gen_care [PatMax];
	int unsigned          gen_len    = 1;
	logic [AddrWidth-1:0] gen_addr   = '0;
	int unsigned          item_total = 0;

	function automatic item_t noise_item();
		item_t it;
		it.opcode        = opcode_t'($urandom_range(0, 3));
		it.pattern_index = IndexWidth'($urandom);
		it.pattern_value = ByteWidth'($urandom);
		it.pattern_care  = 1'($urandom);
		it.data_value    = ByteWidth'($urandom);
		it.data_address  = {$urandom, $urandom};
		return it;
	endfunction

	task automatic queue_item(input item_t r);
		step_t s;
		s.is_write  = 1'b0;
		s.req       = r;
		s.reg_sel   = RegPatternLength;
		s.reg_value = '0;
		pending_q.push_back(s);
		if (r.opcode != OpUnused)
			item_total++;
	endtask

	task automatic queue_write(input reg_index_t sel, input logic [CountWidth-1:0] v);
		step_t s;
		s.is_write  = 1'b1;
		s.req       = '0;
		s.reg_sel   = sel;
		s.reg_value = v;
		pending_q.push_back(s);
		if (sel == RegPatternLength)
			gen_len = (v[LenWidth-1:0] == 0) ? 1 :
				(v[LenWidth-1:0] > PatMax) ? PatMax : v[LenWidth-1:0];
	endtask

	task automatic queue_load(input int unsigned idx, input logic [7:0] v, input logic care);
		item_t it;
		it               = noise_item();
		it.opcode        = OpLoad;
		it.pattern_index = IndexWidth'(idx);
		it.pattern_value = v;
		it.pattern_care  = care;
		gen_pat[idx]     = v;
		gen_care[idx]    = care;
		queue_item(it);
	endtask

	task automatic queue_op(input opcode_t op);
		item_t it;
		it        = noise_item();
		it.opcode = op;
		queue_item(it);
	endtask

	task automatic queue_byte(input logic [7:0] v);
		item_t it;
		it              = noise_item();
		it.opcode       = OpData;
		it.data_value   = v;
		it.data_address = gen_addr;
		gen_addr++;
		queue_item(it);
	endtask

	// Plant the first n positions of the pattern; wildcards get random bytes.
	task automatic queue_instance(input int unsigned n);
		for (int j = 0; j < n; j++)
			queue_byte(gen_care[j] ? gen_pat[j] : 8'($urandom));
	endtask

	function automatic logic [7:0] pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 8'($urandom_range(1, 8));
		if (r < 90)
			return 8'($urandom_range(9, PatMax));
		case ($urandom_range(0, 4))
			0:       return 8'd0;
			1:       return 8'd64;
			2:       return 8'd65;
			3:       return 8'd127;
			default: return 8'hC1;
		endcase
	endfunction

	function automatic logic [7:0] pick_limit();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 8'($urandom_range(1, 6));
		if (r < 80)
			return 8'($urandom_range(7, 255));
		return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
	endfunction

	initial begin
		int unsigned events;
		int unsigned r;

		// Directed: short pattern 00 ? FF AA, limit 3, addresses wrapping past zero.
		queue_write(RegPatternLength, 8'd4);
		queue_write(RegMaxMatches, 8'd3);
		for (int i = 0; i < PatMax; i++)
			queue_load(i, 8'($urandom), 1'($urandom_range(0, 1)));
		queue_load(0, 8'h00, 1'b1);
		queue_load(1, 8'h5A, 1'b0);
		queue_load(2, 8'hFF, 1'b1);
		queue_load(3, 8'hAA, 1'b1);
		queue_op(OpStart);
		gen_addr = 64'hFFFF_FFFF_FFFF_FFFD;
		queue_instance(4);
		queue_op(OpUnused);
		queue_instance(4);
		queue_byte(8'h12);
		queue_instance(4);
		queue_instance(4);
		queue_op(OpStart);
		gen_addr = '1;
		queue_instance(4);

		// Directed: zero length and zero limit both act as one; one wildcard matches anything.
		queue_write(RegPatternLength, 8'd0);
		queue_write(RegMaxMatches, 8'd0);
		queue_load(0, 8'hFF, 1'b0);
		queue_op(OpStart);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'($urandom));

		// Flood: every byte matches, so the count climbs to the top limit and later matches are dropped.
		queue_write(RegPatternLength, 8'h80);
		queue_write(RegMaxMatches, 8'd255);
		queue_op(OpStart);
		gen_addr = {$urandom, $urandom};
		for (int i = 0; i < 260; i++)
			queue_byte(8'($urandom));

		// Random scans: mostly well-formed streams with planted instances, plus noise.
		while (item_total < TargetItems) begin
			if ($urandom_range(0, 4) != 0)
				queue_write(RegPatternLength, pick_length());
			if ($urandom_range(0, 4) != 0)
				queue_write(RegMaxMatches, pick_limit());
			for (int j = 0; j < gen_len; j++)
				queue_load(j, 8'($urandom), $urandom_range(0, 99) < 70);
			if ($urandom_range(0, 9) != 0)
				queue_op(OpStart);
			gen_addr = ($urandom_range(0, 9) == 0)
				? {32'hFFFF_FFFF, 32'hFFFF_FF00 | $urandom_range(0, 255)}
				: {$urandom, $urandom};
			events = (gen_len > 16) ? $urandom_range(3, 8) : $urandom_range(10, 40);
			for (int e = 0; e < events; e++) begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					queue_instance(gen_len);
				end else if (r < 80) begin
					repeat ($urandom_range(1, 5))
						queue_byte(8'($urandom));
				end else if (r < 86) begin
					queue_op(OpUnused);
				end else if (r < 92) begin
					queue_op(OpStart);
				end else if (r < 97) begin
					queue_load($urandom_range(0, PatMax - 1), 8'($urandom),
						1'($urandom_range(0, 1)));
				end else begin
					// Broken instance: a prefix that stops short.
					queue_instance($urandom_range(0, gen_len - 1));
				end
			end
		end

		// Hold reset, then release it away from the rising edge.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: everything sent, every predicted match delivered, then settle.
		while (pending_q.size() != 0 || item_valid || cfg_valid ||
				matches_predicted != matches_seen)
			@(negedge clk);
		repeat (4 * SettleCycles) @(negedge clk);

		if (match_q.size() != 0) begin
			$error("%0d predicted matches never arrived", match_q.size());
			mismatch_count++;
		end

		$display("covered %0d requests (%0d counted as stimulus) and %0d register writes",
			requests_taken, item_total, writes_taken);
		$display("compared %0d matches, %0d field mismatches", matches_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("wildcard_byte_pattern_scanner test passed");
		else
			$display("wildcard_byte_pattern_scanner test failed");
		$finish;
	end

endmodule
